// ----- hdl/msf_pkg.sv -----
// shared widths and constants for the moving average spike filter
package msf_pkg;

  localparam int unsigned SampleW    = 12;
  localparam int unsigned MeanW      = 14;
  localparam int unsigned ThreshW    = 8;
  localparam logic [ThreshW-1:0] ThreshReset = 8'd10;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [MeanW-1:0]   mean_t;
  typedef logic [ThreshW-1:0] thresh_t;

endpackage

// ----- hdl/msf_sample_if.sv -----
// input channel carrying one thermocouple sample per item
interface msf_sample_if;
  logic              valid;
  logic              ready;
  msf_pkg::sample_t  sample_quarter_deg;

  modport source (output valid, output sample_quarter_deg, input ready);
  modport sink   (input valid, input sample_quarter_deg, output ready);
endinterface

// ----- hdl/msf_result_if.sv -----
// output channel carrying one filter result per item
interface msf_result_if;
  logic            valid;
  logic            ready;
  msf_pkg::mean_t  mean_sixteenth_deg;
  logic            rejected;
  logic            ready_res;

  modport source (output valid, output mean_sixteenth_deg, output rejected,
                  output ready_res, input ready);
  modport sink   (input valid, input mean_sixteenth_deg, input rejected,
                  input ready_res, output ready);
endinterface

// ----- hdl/msf_cfg_if.sv -----
// configuration write channel for the spike threshold
interface msf_cfg_if;
  logic              valid;
  logic              ready;
  msf_pkg::thresh_t  spike_threshold_deg;

  modport source (output valid, output spike_threshold_deg, input ready);
  modport sink   (input valid, input spike_threshold_deg, output ready);
endinterface

// ----- hdl/msf_cell.sv -----
// one sample cell of the history chain
module msf_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  msf_pkg::sample_t data_i,
  output msf_pkg::sample_t data_o
);

  msf_pkg::sample_t data_q, data_d;

  always_comb begin
    data_d = shift_i ? data_i : data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ----- hdl/moving_average_spike_filter.sv -----
// moving average with upward spike rejection over a chain of sample cells
// an accepted item's result is in the output register in the cycle after it is accepted
// throughput: one item per cycle while not stalled; the running sum and one compare are combinational
// input is stalled only while a result waits in the output register
// reset: cells, sum, slot count and ready flag clear; threshold returns to 10
// no clearing pass after reset, items are taken in the first cycle
module moving_average_spike_filter #(
  parameter int unsigned RING_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  msf_sample_if.sink    sample_i,
  msf_cfg_if.sink       cfg_i,
  msf_result_if.source  result_o
);

  localparam int unsigned DepthLog = $clog2(RING_DEPTH);
  localparam int unsigned SlotW    = (DepthLog > 0) ? DepthLog : 1;
  localparam int unsigned SumW     = msf_pkg::SampleW + DepthLog;
  localparam int unsigned CmpW     = SumW + 1;
  localparam int unsigned XW       = SumW + 2;
  localparam int unsigned Shift    = XW + DepthLog;
  localparam int unsigned ProdW    = XW + Shift;
  // reciprocal of the depth, exact floor for every value of four times the sum
  localparam logic [Shift-1:0] MeanMul =
    Shift'((2**Shift + RING_DEPTH - 1) / RING_DEPTH);

  msf_pkg::thresh_t thr_q;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             filled_q, filled_d;

  logic             res_valid_q;
  msf_pkg::mean_t   res_mean_q, res_mean_d;
  logic             res_rej_q;
  logic             res_rdy_q;

  msf_pkg::sample_t cell_q [RING_DEPTH];
  logic             accept;
  logic             reject;
  logic             store;
  logic [CmpW-1:0]  lhs, rhs;
  logic [XW-1:0]    sum_x4;
  logic [ProdW-1:0] prod;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = !res_valid_q || result_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;

  // history chain: a stored sample enters the first cell, the last one drops out
  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    msf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(store),
      .data_i ((i == 0) ? sample_i.sample_quarter_deg : cell_q[(i == 0) ? 0 : i - 1]),
      .data_o (cell_q[i])
    );
  end

  always_comb begin
    lhs    = CmpW'(sample_i.sample_quarter_deg) * CmpW'(RING_DEPTH);
    rhs    = CmpW'(sum_q) + CmpW'({thr_q, 2'b00}) * CmpW'(RING_DEPTH);
    reject = filled_q && !(lhs < rhs);
    store  = accept && !reject;

    sum_x4     = {sum_q, 2'b00};
    prod       = ProdW'(sum_x4) * ProdW'(MeanMul);
    res_mean_d = filled_q ? prod[Shift +: msf_pkg::MeanW] : '0;

    sum_d    = sum_q;
    slot_d   = slot_q;
    filled_d = filled_q;
    if (store) begin
      sum_d = sum_q - cell_q[RING_DEPTH-1] + SumW'(sample_i.sample_quarter_deg);
      if (slot_q == SlotW'(RING_DEPTH - 1)) begin
        slot_d   = '0;
        filled_d = 1'b1;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= msf_pkg::ThreshReset;
      sum_q       <= '0;
      slot_q      <= '0;
      filled_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        thr_q <= cfg_i.spike_threshold_deg;
      end
      sum_q    <= sum_d;
      slot_q   <= slot_d;
      filled_q <= filled_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_mean_q <= res_mean_d;
      res_rej_q  <= reject;
      res_rdy_q  <= filled_d;
    end
  end

  assign result_o.valid              = res_valid_q;
  assign result_o.mean_sixteenth_deg = res_mean_q;
  assign result_o.rejected           = res_rej_q;
  assign result_o.ready_res          = res_rdy_q;

`ifndef SYNTHESIS
  a_rej_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.rejected |-> result_o.ready_res)
    else $error("rejected item reported before the ring was filled");

  a_mean_zero_before_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready_res |-> result_o.mean_sixteenth_deg == '0)
    else $error("nonzero mean before the ring was filled");

  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && reject |=> $stable(sum_q) && $stable(slot_q))
    else $error("rejected item changed the running sum or slot");

  a_filled_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q |=> filled_q)
    else $error("ready flag dropped");
`endif

endmodule
